// ----- rtl/variable_length_ring_buffer_unit_assert.svh -----
// Assertion macros used by the ring buffer core.
`ifndef VARIABLE_LENGTH_RING_BUFFER_UNIT_ASSERT_SVH
`define VARIABLE_LENGTH_RING_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VLRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VLRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/vlrb_pkg.sv -----
// Shared constants, codes and types of the variable length ring buffer.
package vlrb_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int MAX_MSGS  = 256;

  localparam int MODE_W    = 2;
  localparam int LEN_W     = 13;
  localparam int STATUS_W  = 2;
  localparam int OUT_OFF_W = 12;
  localparam int OUT_CNT_W = 9;

  localparam int OFF_W = $clog2(BUF_BYTES + 1);
  localparam int SUM_W = OFF_W + 1;
  localparam int PTR_W = $clog2(MAX_MSGS);
  localparam int CNT_W = $clog2(MAX_MSGS + 1);

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_LEN_FULL = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_OFF_W-1:0] offset;
    logic [LEN_W-1:0]     length;
    logic                 is_empty;
    logic [OUT_CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [LEN_W-1:0] data;
  } len_wr_t;

endpackage

// ----- rtl/vlrb_ifs.sv -----
// Valid/ready channel interfaces for the ring buffer input and result beats.
interface vlrb_in_if;
  logic                       valid;
  logic                       ready;
  logic [vlrb_pkg::MODE_W-1:0] mode;
  logic [vlrb_pkg::LEN_W-1:0]  msg_length;

  modport source (output valid, output mode, output msg_length, input ready);
  modport sink   (input valid, input mode, input msg_length, output ready);
endinterface

interface vlrb_out_if;
  logic                           valid;
  logic                           ready;
  logic [vlrb_pkg::STATUS_W-1:0]  status;
  logic [vlrb_pkg::OUT_OFF_W-1:0] offset;
  logic [vlrb_pkg::LEN_W-1:0]     length;
  logic                           is_empty;
  logic [vlrb_pkg::OUT_CNT_W-1:0] count;

  modport source (output valid, output status, output offset, output length,
                  output is_empty, output count, input ready);
  modport sink   (input valid, input status, input offset, input length,
                  input is_empty, input count, output ready);
endinterface

// ----- rtl/vlrb_len_store.sv -----
// Message length FIFO storage: one write port, one registered read port with write bypass.
module vlrb_len_store (
  input  logic                        clk,
  input  vlrb_pkg::len_wr_t           wr,
  input  logic [vlrb_pkg::PTR_W-1:0]  rd_addr,
  output logic [vlrb_pkg::LEN_W-1:0]  rd_data
);

  logic [vlrb_pkg::LEN_W-1:0] len_mem [vlrb_pkg::MAX_MSGS];
  logic [vlrb_pkg::LEN_W-1:0] rd_data_r;
  logic [vlrb_pkg::LEN_W-1:0] byp_data_r;
  logic                       byp_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      len_mem[wr.addr] <= wr.data;
    end
    rd_data_r  <= len_mem[rd_addr];
    byp_r      <= wr.en && (wr.addr == rd_addr);
    byp_data_r <= wr.data;
  end

  // A write to the address being read wins over the old array contents.
  assign rd_data = byp_r ? byp_data_r : rd_data_r;

endmodule

// ----- rtl/vlrb_core.sv -----
// Offset bookkeeping: head, tail, count, wrap mark and length FIFO pointers.
module vlrb_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [vlrb_pkg::MODE_W-1:0] mode,
  input  logic [vlrb_pkg::LEN_W-1:0]  msg_length,
  input  logic [vlrb_pkg::LEN_W-1:0]  head_len,
  output vlrb_pkg::res_t              res,
  output vlrb_pkg::len_wr_t           len_wr,
  output logic [vlrb_pkg::PTR_W-1:0]  rd_addr
);

  `include "variable_length_ring_buffer_unit_assert.svh"

  logic [vlrb_pkg::OFF_W-1:0] head_r, head_nxt;
  logic [vlrb_pkg::OFF_W-1:0] tail_r, tail_nxt;
  logic [vlrb_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                       wrap_valid_r, wrap_valid_nxt;
  logic [vlrb_pkg::OFF_W-1:0] wrap_point_r, wrap_point_nxt;
  logic [vlrb_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [vlrb_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;

  logic [vlrb_pkg::SUM_W-1:0] end_sum;
  logic [vlrb_pkg::SUM_W-1:0] head_sum;
  logic [vlrb_pkg::OFF_W-1:0] oldest;
  logic [vlrb_pkg::OFF_W-1:0] where;
  logic                       at_wrap;
  logic                       wraps;
  logic                       fits;
  logic [vlrb_pkg::PTR_W-1:0] wr_ptr_inc;
  logic [vlrb_pkg::PTR_W-1:0] rd_ptr_inc;

  logic                       count_ok;
  logic                       ptr_gap_ok;
  logic                       enq_done;

  always_comb begin
    at_wrap  = wrap_valid_r && (head_r == wrap_point_r);
    oldest   = at_wrap ? '0 : head_r;
    end_sum  = vlrb_pkg::SUM_W'(tail_r) + vlrb_pkg::SUM_W'(msg_length);
    head_sum = vlrb_pkg::SUM_W'(oldest) + vlrb_pkg::SUM_W'(head_len);
    wraps    = !wrap_valid_r && (end_sum > vlrb_pkg::SUM_W'(vlrb_pkg::BUF_BYTES));
    if (wraps) begin
      fits = vlrb_pkg::SUM_W'(msg_length) <= vlrb_pkg::SUM_W'(head_r);
    end else if (wrap_valid_r) begin
      fits = end_sum <= vlrb_pkg::SUM_W'(head_r);
    end else begin
      fits = 1'b1;
    end
    where      = wraps ? '0 : tail_r;
    wr_ptr_inc = (wr_ptr_r == vlrb_pkg::PTR_W'(vlrb_pkg::MAX_MSGS - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    rd_ptr_inc = (rd_ptr_r == vlrb_pkg::PTR_W'(vlrb_pkg::MAX_MSGS - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    wrap_valid_nxt = wrap_valid_r;
    wrap_point_nxt = wrap_point_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    len_wr.en      = 1'b0;
    len_wr.addr    = wr_ptr_r;
    len_wr.data    = msg_length;
    res.status     = vlrb_pkg::ST_OK;
    res.offset     = '0;
    res.length     = '0;

    unique case (mode)
      vlrb_pkg::MODE_ENQ: begin
        if (count_r >= vlrb_pkg::CNT_W'(vlrb_pkg::MAX_MSGS)) begin
          res.status = vlrb_pkg::ST_LEN_FULL;
        end else if (vlrb_pkg::SUM_W'(msg_length) > vlrb_pkg::SUM_W'(vlrb_pkg::BUF_BYTES)) begin
          res.status = vlrb_pkg::ST_FULL;
        end else if (!fits) begin
          res.status = vlrb_pkg::ST_FULL;
        end else begin
          res.offset = where[vlrb_pkg::OUT_OFF_W-1:0];
          // Record the old tail as the wrap point when the wrap skips bytes.
          if (wraps && (tail_r != '0)) begin
            wrap_valid_nxt = step ? 1'b1 : wrap_valid_r;
            wrap_point_nxt = step ? tail_r : wrap_point_r;
          end
          if (step) begin
            tail_nxt   = wraps ? vlrb_pkg::OFF_W'(msg_length) : end_sum[vlrb_pkg::OFF_W-1:0];
            len_wr.en  = 1'b1;
            wr_ptr_nxt = wr_ptr_inc;
            count_nxt  = count_r + 1'b1;
          end
        end
      end
      vlrb_pkg::MODE_DEQ, vlrb_pkg::MODE_PEEK: begin
        if (count_r == '0) begin
          res.status = vlrb_pkg::ST_EMPTY;
        end else begin
          res.offset = oldest[vlrb_pkg::OUT_OFF_W-1:0];
          res.length = head_len;
          if (step && (mode == vlrb_pkg::MODE_DEQ)) begin
            if (at_wrap) begin
              wrap_valid_nxt = 1'b0;
            end
            head_nxt   = head_sum[vlrb_pkg::OFF_W-1:0];
            rd_ptr_nxt = rd_ptr_inc;
            count_nxt  = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // Count and empty flag report the state after this beat.
    res.count    = vlrb_pkg::OUT_CNT_W'(count_nxt);
    res.is_empty = (count_nxt == '0);
  end

  // Prefetch the length of the oldest message for the next beat.
  assign rd_addr = rst_n ? rd_ptr_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      wrap_valid_r <= 1'b0;
      wrap_point_r <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      wrap_valid_r <= wrap_valid_nxt;
      wrap_point_r <= wrap_point_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
    end
  end

  assign count_ok   = (count_r <= vlrb_pkg::CNT_W'(vlrb_pkg::MAX_MSGS));
  assign ptr_gap_ok = (vlrb_pkg::PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[vlrb_pkg::PTR_W-1:0]);
  assign enq_done   = step && (mode == vlrb_pkg::MODE_ENQ) && (res.status == vlrb_pkg::ST_OK);

  `VLRB_ASSERT_NOW(a_count_bound, 1'b1, count_ok, "message count above capacity")
  `VLRB_ASSERT_NOW(a_ptr_gap, 1'b1, ptr_gap_ok, "length FIFO pointers disagree with count")
  `VLRB_ASSERT_NEXT(a_enq_count, enq_done, count_r == $past(count_r) + 1'b1, "count did not rise")

endmodule

// ----- rtl/variable_length_ring_buffer_unit.sv -----
// Top level of the variable length ring buffer offset manager.
//
//   Channel  Role    Payload                                        Handshake
//   in_ch    sink    mode, msg_length                               valid/ready
//   out_ch   source  status, offset, length, is_empty, count        valid/ready
//
// Register a beat on acceptance and resolve it when it advances into the output register;
// the result is offered from there, one beat per cycle while out_ch.ready is high.
// Prefetch the oldest length each cycle, so a dequeue or peek may follow anything.
// Reset (rst_n low, synchronous) empties the buffer; the length store is not cleared.
// While out_ch stalls with both registers full, hold both beats and drop in_ch.ready;
// a single waiting result never blocks the input.
module variable_length_ring_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  vlrb_in_if.sink     in_ch,
  vlrb_out_if.source  out_ch
);

  // Input register.
  logic                        s1_valid_r;
  logic [vlrb_pkg::MODE_W-1:0] s1_mode_r;
  logic [vlrb_pkg::LEN_W-1:0]  s1_len_r;

  // Output register.
  logic                        out_valid_r;
  vlrb_pkg::res_t              out_res_r;

  logic                        s1_fire;
  logic                        in_ready;
  vlrb_pkg::res_t              core_res;
  vlrb_pkg::len_wr_t           len_wr;
  logic [vlrb_pkg::PTR_W-1:0]  rd_addr;
  logic [vlrb_pkg::LEN_W-1:0]  head_len;

  // Advance the held beat whenever the output register is free or draining.
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_len_r  <= in_ch.msg_length;
    end
  end

  vlrb_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_fire),
    .mode       (s1_mode_r),
    .msg_length (s1_len_r),
    .head_len   (head_len),
    .res        (core_res),
    .len_wr     (len_wr),
    .rd_addr    (rd_addr)
  );

  vlrb_len_store u_len_store (
    .clk     (clk),
    .wr      (len_wr),
    .rd_addr (rd_addr),
    .rd_data (head_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result only when a beat advances; hold it otherwise.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_res_r.status;
  assign out_ch.offset   = out_res_r.offset;
  assign out_ch.length   = out_res_r.length;
  assign out_ch.is_empty = out_res_r.is_empty;
  assign out_ch.count    = out_res_r.count;

endmodule

// ----- bench/ring_offset_checker.sv -----
// Checker that predicts each ring buffer result from the input beats and compares it.
module ring_offset_checker
  import vlrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vlrb_in_if   in_ch,
  vlrb_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  // Offset state of the buffer as the block should hold it.
  int unsigned      head_at;
  int unsigned      tail_at;
  int unsigned      stored;
  int unsigned      wrap_at;
  int unsigned      wr_slot;
  int unsigned      rd_slot;
  bit               wrap_pending;
  logic [LEN_W-1:0] len_fifo [MAX_MSGS];

  res_t expected_results [$];

  // Apply one request to the offset state and return the result it causes.
  function automatic res_t resolve_request(logic [MODE_W-1:0] mode, logic [LEN_W-1:0] len);
    res_t        r;
    int unsigned stop;
    int unsigned place;
    bit          wraps;
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_ENQ: begin
        wraps = 1'b0;
        stop = tail_at + len;
        if (stored >= MAX_MSGS) begin
          r.status = ST_LEN_FULL;
        end else if (len > BUF_BYTES) begin
          r.status = ST_FULL;
        end else begin
          // restart at zero when the message runs past the end, once only
          if (!wrap_pending && stop > BUF_BYTES) begin
            stop = len;
            wraps = 1'b1;
          end
          if ((wraps || wrap_pending) && stop > head_at) begin
            r.status = ST_FULL;
          end else begin
            place = stop - len;
            if (wraps && tail_at > 0) begin
              wrap_pending = 1'b1;
              wrap_at = tail_at;
            end
            tail_at = stop;
            len_fifo[wr_slot] = len;
            wr_slot = (wr_slot + 1) % MAX_MSGS;
            stored++;
            r.offset = place[OUT_OFF_W-1:0];
          end
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (stored == 0) begin
          r.status = ST_EMPTY;
        end else begin
          place = (wrap_pending && head_at == wrap_at) ? 0 : head_at;
          r.offset = place[OUT_OFF_W-1:0];
          r.length = len_fifo[rd_slot];
          if (mode == MODE_DEQ) begin
            if (wrap_pending && head_at == wrap_at) wrap_pending = 1'b0;
            head_at = place + len_fifo[rd_slot];
            rd_slot = (rd_slot + 1) % MAX_MSGS;
            stored--;
          end
        end
      end
      default: ;
    endcase
    r.is_empty = (stored == 0);
    r.count = stored[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      head_at = 0;
      tail_at = 0;
      stored = 0;
      wrap_at = 0;
      wr_slot = 0;
      rd_slot = 0;
      wrap_pending = 1'b0;
      fail_count = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(resolve_request(in_ch.mode, in_ch.msg_length));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request waiting");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("offset", want.offset, out_ch.offset);
          check_field("length", want.length, out_ch.length);
          check_field("is_empty", want.is_empty, out_ch.is_empty);
          check_field("count", want.count, out_ch.count);
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the ring buffer bench: clock, reset, stimulus, result stalls and verdict.
module tb_top;
  import vlrb_pkg::*;

  // The fourth mode code has no meaning in the block; it must change nothing.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {PH_MIXED, PH_BULK, PH_DRAIN} phase_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit send_gapless = 1'b0;
  bit take_gapless = 1'b0;

  vlrb_in_if  in_ch ();
  vlrb_out_if out_ch ();

  variable_length_ring_buffer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ring_offset_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(input logic [MODE_W-1:0] m, input int unsigned len);
    int gap;
    gap = send_gapless ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.msg_length <= len[LEN_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Mostly lengths that let many messages share the buffer; a few oversized
  // ones, the exact buffer size and zero; bulky phases push toward full.
  function automatic int unsigned draw_length(bit bulky);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(BUF_BYTES + 1, (1 << LEN_W) - 1);
    if (roll < 5) return (roll == 3) ? BUF_BYTES : 0;
    return bulky ? $urandom_range(256, 2500) : $urandom_range(0, 400);
  endfunction

  // Result side: stall a random number of cycles before each beat, with
  // stretches of no stalling at all.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) take_gapless = !take_gapless;
      stall = take_gapless ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                sent;
    int                phase_len;
    int                enq_share;
    int unsigned       roll;
    phase_t            phase;
    logic [MODE_W-1:0] op;

    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_ENQ;
    in_ch.msg_length = '0;

    // Hold reset at the start, then release it for good.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every mode, field extremes and the corner cases.
    send_beat(MODE_PEEK, 0);            // peek on an empty queue
    send_beat(MODE_DEQ, 0);             // dequeue on an empty queue
    send_beat(MODE_ENQ, BUF_BYTES);     // one message fills the whole buffer
    send_beat(MODE_ENQ, 0);             // zero-length message at the very end
    send_beat(MODE_ENQ, 1);             // wrap would pass the head: full
    send_beat(MODE_ENQ, 8191);          // oversized, widest length
    send_beat(MODE_ENQ, BUF_BYTES + 1); // oversized by one byte
    send_beat(MODE_UNUSED, 8191);       // unused mode changes nothing
    send_beat(MODE_PEEK, 0);
    send_beat(MODE_DEQ, 0);
    send_beat(MODE_DEQ, 0);             // read offset at buffer end, masked
    send_beat(MODE_ENQ, 100);           // wraps and sets the mark
    send_beat(MODE_PEEK, 0);            // head on the wrap point: jump to zero
    send_beat(MODE_DEQ, 0);             // jump to zero and clear the mark
    send_beat(MODE_ENQ, 3900);
    send_beat(MODE_ENQ, 200);           // wrap blocked by the head
    send_beat(MODE_DEQ, 0);
    send_beat(MODE_ENQ, 200);           // wraps again
    send_beat(MODE_ENQ, 4000);          // second wrap refused
    send_beat(MODE_ENQ, 3800);          // ends exactly on the head
    send_beat(MODE_DEQ, 0);
    send_beat(MODE_DEQ, 0);
    send_beat(MODE_DEQ, 0);             // empty again

    // Fill the length store with tiny messages until it refuses.
    for (int i = 0; i < MAX_MSGS + 4; i++) send_beat(MODE_ENQ, $urandom_range(0, 3));
    sent = MAX_MSGS + 4;

    // Random phases: mixed traffic, bulky enqueues, and drains.
    while (sent < RANDOM_ITEMS) begin
      phase = phase_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 60);
      send_gapless = ($urandom_range(0, 3) == 0);
      case (phase)
        PH_MIXED: enq_share = 50;
        PH_BULK:  enq_share = 70;
        default:  enq_share = 15;
      endcase
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) op = MODE_UNUSED;
        else if (roll < enq_share) op = MODE_ENQ;
        else if (roll < enq_share + 12) op = MODE_PEEK;
        else op = MODE_DEQ;
        send_beat(op, draw_length(phase == PH_BULK));
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every expected result, then idle before the verdict.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
